// ===== src/rgba_ovl_pkg.sv =====
// Shared types and constants for the RGBA overlay compositor.
// No dependencies.
package rgba_ovl_pkg;

	localparam int OVL_MAX_W_DEF  = 256;
	localparam int OVL_MAX_H_DEF  = 64;
	localparam int COORD_BITS_DEF = 12;

	localparam int OFFSET_W = 13;
	localparam int SIZE_W_W = 9;
	localparam int SIZE_H_W = 7;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 2;

	localparam int ENTRY_W = 32;
	localparam int CH_W    = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OFFSET_X = 2'd0,
		REG_OFFSET_Y = 2'd1,
		REG_OVL_W    = 2'd2,
		REG_OVL_H    = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		OP_LOAD    = 1'b0,
		OP_COMPOSE = 1'b1
	} op_t;

endpackage

// ===== src/rgba_ovl_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module rgba_ovl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/rgba_overlay_alpha_compositor_unit.sv =====
// RGBA overlay compositor: overlay store in RAM, alpha blend onto BGR frame pixels.
// Compose results reach done through the store read, sum and divide registers.
// Throughput: one item per clock; busy stays low, the store takes a load write and a
// compose read on separate ports. The receiver cannot stall; done lasts one cycle.
// Reset clears the pipeline and configuration; store contents are undefined until loaded.
// Depends on rgba_ovl_pkg and rgba_ovl_ram.
module rgba_overlay_alpha_compositor_unit
	import rgba_ovl_pkg::*;
#(
	parameter int OVL_MAX_W  = OVL_MAX_W_DEF,
	parameter int OVL_MAX_H  = OVL_MAX_H_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  start,
	output logic                  busy,
	input  logic                  opcode,
	input  logic [COORD_BITS-1:0] pos_x,
	input  logic [COORD_BITS-1:0] pos_y,
	input  logic [CH_W-1:0]       frame_blue,
	input  logic [CH_W-1:0]       frame_green,
	input  logic [CH_W-1:0]       frame_red,
	input  logic [CH_W-1:0]       ovl_red,
	input  logic [CH_W-1:0]       ovl_green,
	input  logic [CH_W-1:0]       ovl_blue,
	input  logic [CH_W-1:0]       ovl_alpha,
	output logic                  done,
	output logic [CH_W-1:0]       out_blue,
	output logic [CH_W-1:0]       out_green,
	output logic [CH_W-1:0]       out_red,
	output logic [COORD_BITS-1:0] out_x,
	output logic [COORD_BITS-1:0] out_y
);

	localparam int CW    = $clog2(OVL_MAX_W);
	localparam int RW    = $clog2(OVL_MAX_H);
	localparam int AW    = CW + RW;
	localparam int DEPTH = 1 << AW;
	localparam int DW    = ((COORD_BITS > OFFSET_W - 1) ? COORD_BITS : OFFSET_W - 1) + 2;
	localparam int PW    = 2 * CH_W;

	logic [OFFSET_W-1:0] offset_x_q;
	logic [OFFSET_W-1:0] offset_y_q;
	logic [SIZE_W_W-1:0] ovl_w_q;
	logic [SIZE_H_W-1:0] ovl_h_q;

	logic accept;
	logic ram_we;
	logic ram_re;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	logic [ENTRY_W-1:0] wdata;
	logic [ENTRY_W-1:0] rdata;
	logic signed [DW-1:0] ox;
	logic signed [DW-1:0] oy;
	logic in_area;
	logic load_ok;

	logic                  vld_s1;
	logic                  in_area_s1;
	logic [CH_W-1:0]       fb_s1, fg_s1, fr_s1;
	logic [COORD_BITS-1:0] x_s1, y_s1;

	logic                  vld_s2;
	logic [PW-1:0]         sb_s2, sg_s2, sr_s2;
	logic [COORD_BITS-1:0] x_s2, y_s2;

	logic [CH_W-1:0] alpha;
	logic [CH_W-1:0] alpha_inv;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_x_q <= '0;
			offset_y_q <= '0;
			ovl_w_q    <= '0;
			ovl_h_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_OFFSET_X: offset_x_q <= cfg_wdata[OFFSET_W-1:0];
				REG_OFFSET_Y: offset_y_q <= cfg_wdata[OFFSET_W-1:0];
				REG_OVL_W:    ovl_w_q    <= cfg_wdata[SIZE_W_W-1:0];
				REG_OVL_H:    ovl_h_q    <= cfg_wdata[SIZE_H_W-1:0];
			endcase
		end
	end

	// overlay coordinate and bounds
	assign ox = $signed(DW'(pos_x)) - DW'($signed(offset_x_q));
	assign oy = $signed(DW'(pos_y)) - DW'($signed(offset_y_q));

	assign in_area = !ox[DW-1] && !oy[DW-1]
		&& (ox < $signed(DW'(ovl_w_q))) && (ox < $signed(DW'(OVL_MAX_W)))
		&& (oy < $signed(DW'(ovl_h_q))) && (oy < $signed(DW'(OVL_MAX_H)));

	assign load_ok = (32'(pos_x) < 32'(OVL_MAX_W)) && (32'(pos_y) < 32'(OVL_MAX_H));

	assign ram_we = accept && (op_t'(opcode) == OP_LOAD) && load_ok;
	assign ram_re = accept && (op_t'(opcode) == OP_COMPOSE);
	assign waddr  = {pos_y[RW-1:0], pos_x[CW-1:0]};
	assign raddr  = {oy[RW-1:0], ox[CW-1:0]};
	assign wdata  = {ovl_alpha, ovl_blue, ovl_green, ovl_red};

	rgba_ovl_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (ram_re),
		.raddr(raddr),
		.rdata(rdata)
	);

	// stage 1: store read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= ram_re;
		end
	end

	always_ff @(posedge clk) begin
		in_area_s1 <= in_area;
		fb_s1      <= frame_blue;
		fg_s1      <= frame_green;
		fr_s1      <= frame_red;
		x_s1       <= pos_x;
		y_s1       <= pos_y;
	end

	// stage 2: weighted sums; alpha 0 outside the overlay passes the frame pixel
	assign alpha     = in_area_s1 ? rdata[31:24] : '0;
	assign alpha_inv = CH_W'(8'd255) - alpha;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		sb_s2 <= PW'(rdata[23:16]) * PW'(alpha) + PW'(fb_s1) * PW'(alpha_inv);
		sg_s2 <= PW'(rdata[15:8])  * PW'(alpha) + PW'(fg_s1) * PW'(alpha_inv);
		sr_s2 <= PW'(rdata[7:0])   * PW'(alpha) + PW'(fr_s1) * PW'(alpha_inv);
		x_s2  <= x_s1;
		y_s2  <= y_s1;
	end

	// stage 3: divide by 255, exact for sums up to 255*255
	function automatic logic [CH_W-1:0] div255(input logic [PW-1:0] s);
		logic [PW-1:0] t;
		t = s + PW'(s[PW-1:CH_W]) + PW'(1);
		return t[PW-1:CH_W];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		out_blue  <= div255(sb_s2);
		out_green <= div255(sg_s2);
		out_red   <= div255(sr_s2);
		out_x     <= x_s2;
		out_y     <= y_s2;
	end

	a_compose_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && opcode == OP_COMPOSE) |-> ##3 (done && out_x == $past(pos_x, 3)
			&& out_y == $past(pos_y, 3)))
		else $error("compose item lost or misplaced");

	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && opcode == OP_LOAD) |-> ##3 !done)
		else $error("load item gave a result");

	a_port_split: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("store write and read in one cycle");

endmodule

// ===== dv/ovl_blend_sb_pkg.sv =====
// Scoreboard for the overlay compositor: keeps its own overlay store and registers,
// works out each composed pixel and checks results in order of arrival.
// Depends on rgba_ovl_pkg.
package ovl_blend_sb_pkg;
	timeunit 1ns;
	timeprecision 1ps;
	import rgba_ovl_pkg::*;

	localparam int STORE_DEPTH = OVL_MAX_W_DEF * OVL_MAX_H_DEF;
	localparam int MAX_REPORTS = 40;

	typedef struct packed {
		op_t                       opcode;
		logic [COORD_BITS_DEF-1:0] pos_x;
		logic [COORD_BITS_DEF-1:0] pos_y;
		logic [CH_W-1:0]           frame_blue;
		logic [CH_W-1:0]           frame_green;
		logic [CH_W-1:0]           frame_red;
		logic [CH_W-1:0]           ovl_red;
		logic [CH_W-1:0]           ovl_green;
		logic [CH_W-1:0]           ovl_blue;
		logic [CH_W-1:0]           ovl_alpha;
	} pixel_item_t;

	typedef struct packed {
		logic [CH_W-1:0]           blue;
		logic [CH_W-1:0]           green;
		logic [CH_W-1:0]           red;
		logic [COORD_BITS_DEF-1:0] x;
		logic [COORD_BITS_DEF-1:0] y;
	} pixel_out_t;

	class overlay_scoreboard;
		logic [ENTRY_W-1:0]         store [STORE_DEPTH];
		bit                         written [STORE_DEPTH];
		logic signed [OFFSET_W-1:0] off_x;
		logic signed [OFFSET_W-1:0] off_y;
		logic [SIZE_W_W-1:0]        ovl_w;
		logic [SIZE_H_W-1:0]        ovl_h;
		pixel_out_t                 pending [$];
		int errors;
		int composed;
		int opaque;
		int blended;
		int unchanged;
		int loads;
		int dropped_loads;

		function new();
			off_x = '0;
			off_y = '0;
			ovl_w = '0;
			ovl_h = '0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
			case (idx)
				REG_OFFSET_X: off_x = d[OFFSET_W-1:0];
				REG_OFFSET_Y: off_y = d[OFFSET_W-1:0];
				REG_OVL_W:    ovl_w = d[SIZE_W_W-1:0];
				REG_OVL_H:    ovl_h = d[SIZE_H_W-1:0];
				default: ;
			endcase
		endfunction

		// store index under a frame position, or -1 outside the active overlay
		function int ovl_index(logic [COORD_BITS_DEF-1:0] px, logic [COORD_BITS_DEF-1:0] py);
			int ew;
			int eh;
			int ox;
			int oy;
			ew = (ovl_w > OVL_MAX_W_DEF) ? OVL_MAX_W_DEF : int'(ovl_w);
			eh = (ovl_h > OVL_MAX_H_DEF) ? OVL_MAX_H_DEF : int'(ovl_h);
			ox = int'(px) - int'(off_x);
			oy = int'(py) - int'(off_y);
			if (ox >= 0 && oy >= 0 && ox < ew && oy < eh)
				return oy * OVL_MAX_W_DEF + ox;
			return -1;
		endfunction

		function logic [CH_W-1:0] mix(logic [CH_W-1:0] o, logic [CH_W-1:0] f, int unsigned a);
			int unsigned v;
			v = (o * a + f * (255 - a)) / 255;
			return v[CH_W-1:0];
		endfunction

		function void note_item(pixel_item_t it);
			int idx;
			int unsigned a;
			logic [ENTRY_W-1:0] e;
			pixel_out_t res;
			if (it.opcode == OP_LOAD) begin
				if (it.pos_x < OVL_MAX_W_DEF && it.pos_y < OVL_MAX_H_DEF) begin
					idx = int'(it.pos_y) * OVL_MAX_W_DEF + int'(it.pos_x);
					store[idx] = {it.ovl_alpha, it.ovl_blue, it.ovl_green, it.ovl_red};
					written[idx] = 1'b1;
					loads++;
				end else
					dropped_loads++;
				return;
			end
			composed++;
			res.blue = it.frame_blue;
			res.green = it.frame_green;
			res.red = it.frame_red;
			res.x = it.pos_x;
			res.y = it.pos_y;
			idx = ovl_index(it.pos_x, it.pos_y);
			e = (idx >= 0) ? store[idx] : '0;
			a = e[31:24];
			if (a == 255) begin
				res.blue = e[23:16];
				res.green = e[15:8];
				res.red = e[7:0];
				opaque++;
			end else if (a != 0) begin
				res.blue = mix(e[23:16], it.frame_blue, a);
				res.green = mix(e[15:8], it.frame_green, a);
				res.red = mix(e[7:0], it.frame_red, a);
				blended++;
			end else
				unchanged++;
			pending.push_back(res);
		endfunction

		function bit report(string field, int want, int got);
			if (want == got)
				return 1'b0;
			if (errors < MAX_REPORTS)
				$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
			return 1'b1;
		endfunction

		function void check_result(pixel_out_t got);
			pixel_out_t want;
			bit bad;
			if (pending.size() == 0) begin
				if (errors < MAX_REPORTS)
					$display("%0t ns: unexpected pixel b=%0d g=%0d r=%0d at (%0d,%0d)",
						$time, got.blue, got.green, got.red, got.x, got.y);
				errors++;
				return;
			end
			want = pending.pop_front();
			bad = 1'b0;
			bad |= report("out_blue", want.blue, got.blue);
			bad |= report("out_green", want.green, got.green);
			bad |= report("out_red", want.red, got.red);
			bad |= report("out_x", want.x, got.x);
			bad |= report("out_y", want.y, got.y);
			if (bad)
				errors++;
		endfunction
	endclass

endpackage

// ===== dv/tb.sv =====
// Testbench for rgba_overlay_alpha_compositor_unit: directed and random load/compose
// items under several register settings, checked by the overlay scoreboard.
// Depends on rgba_ovl_pkg, ovl_blend_sb_pkg and the compositor RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rgba_ovl_pkg::*;
	import ovl_blend_sb_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int COORD_MAX    = (1 << COORD_BITS_DEF) - 1;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic start;
	logic busy;
	logic done;
	pixel_item_t item;
	logic [CH_W-1:0] out_blue;
	logic [CH_W-1:0] out_green;
	logic [CH_W-1:0] out_red;
	logic [COORD_BITS_DEF-1:0] out_x;
	logic [COORD_BITS_DEF-1:0] out_y;

	overlay_scoreboard sb = new();
	int taken = 0;
	int cycles = 0;
	int phases = 0;
	int idle_pct;

	rgba_overlay_alpha_compositor_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.start       (start),
		.busy        (busy),
		.opcode      (item.opcode),
		.pos_x       (item.pos_x),
		.pos_y       (item.pos_y),
		.frame_blue  (item.frame_blue),
		.frame_green (item.frame_green),
		.frame_red   (item.frame_red),
		.ovl_red     (item.ovl_red),
		.ovl_green   (item.ovl_green),
		.ovl_blue    (item.ovl_blue),
		.ovl_alpha   (item.ovl_alpha),
		.done        (done),
		.out_blue    (out_blue),
		.out_green   (out_green),
		.out_red     (out_red),
		.out_x       (out_x),
		.out_y       (out_y)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		pixel_out_t seen;
		if (arst_n) begin
			if (done) begin
				seen.blue = out_blue;
				seen.green = out_green;
				seen.red = out_red;
				seen.x = out_x;
				seen.y = out_y;
				sb.check_result(seen);
			end
			if (cfg_we)
				sb.set_reg(cfg_reg_t'(cfg_addr), cfg_wdata);
			if (start && !busy) begin
				sb.note_item(item);
				taken++;
			end
		end
	end

	function automatic pixel_item_t mk_item(op_t op, int x, int y);
		logic [95:0] r;
		pixel_item_t it;
		r = {$urandom, $urandom, $urandom};
		it = pixel_item_t'(r[$bits(pixel_item_t)-1:0]);
		it.opcode = op;
		it.pos_x = COORD_BITS_DEF'(x);
		it.pos_y = COORD_BITS_DEF'(y);
		if (op == OP_LOAD) begin
			case ($urandom_range(5))
				0: it.ovl_alpha = 8'd0;
				1: it.ovl_alpha = 8'd255;
				2: it.ovl_alpha = 8'd1;
				3: it.ovl_alpha = 8'd254;
				default: ;
			endcase
		end
		return it;
	endfunction

	function automatic int pick_offset();
		case ($urandom_range(6))
			0: return -4096;
			1: return 4095;
			2: return 0;
			3: return int'($urandom_range(8191)) - 4096;
			4: return -int'($urandom_range(1, 300));
			default: return int'($urandom_range(600));
		endcase
	endfunction

	task automatic send(pixel_item_t it);
		int n0;
		while ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		item = it;
		start = 1'b1;
		n0 = taken;
		do @(negedge clk); while (taken == n0);
	endtask

	// load an entry first where the compose would read one never written
	task automatic compose_at(int x, int y);
		int idx;
		idx = sb.ovl_index(COORD_BITS_DEF'(x), COORD_BITS_DEF'(y));
		if (idx >= 0 && !sb.written[idx])
			send(mk_item(OP_LOAD, idx % OVL_MAX_W_DEF, idx / OVL_MAX_W_DEF));
		send(mk_item(OP_COMPOSE, x, y));
	endtask

	task automatic load_px(int x, int y, int r, int g, int b, int a);
		pixel_item_t it;
		it = mk_item(OP_LOAD, x, y);
		it.ovl_red = CH_W'(r);
		it.ovl_green = CH_W'(g);
		it.ovl_blue = CH_W'(b);
		it.ovl_alpha = CH_W'(a);
		send(it);
	endtask

	task automatic compose_px(int x, int y, int level);
		pixel_item_t it;
		it = mk_item(OP_COMPOSE, x, y);
		it.frame_blue = CH_W'(level);
		it.frame_green = CH_W'(level);
		it.frame_red = CH_W'(level);
		send(it);
	endtask

	task automatic drain();
		start = 1'b0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
		cfg_addr = idx;
		cfg_wdata = d;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic configure(int ox, int oy, int w, int h);
		logic [CFG_DATA_W-1:0] junk;
		drain();
		junk = CFG_DATA_W'($urandom);
		write_reg(REG_OFFSET_X, CFG_DATA_W'(ox));
		write_reg(REG_OFFSET_Y, CFG_DATA_W'(oy));
		write_reg(REG_OVL_W, {junk[CFG_DATA_W-1:SIZE_W_W], SIZE_W_W'(w)});
		write_reg(REG_OVL_H, {junk[CFG_DATA_W-1:SIZE_H_W], SIZE_H_W'(h)});
		phases++;
	endtask

	task automatic random_phase(int n_items, int gap_pct);
		int ox;
		int oy;
		int w;
		int h;
		int ew;
		int eh;
		int x;
		int y;
		int r;
		ox = pick_offset();
		oy = pick_offset();
		case ($urandom_range(6))
			0: w = 0;
			1: w = OVL_MAX_W_DEF;
			2: w = $urandom_range(OVL_MAX_W_DEF + 1, 511);
			3: w = $urandom_range(1, 4);
			default: w = $urandom_range(1, 40);
		endcase
		case ($urandom_range(6))
			0: h = 0;
			1: h = OVL_MAX_H_DEF;
			2: h = $urandom_range(OVL_MAX_H_DEF + 1, 127);
			default: h = $urandom_range(1, 12);
		endcase
		configure(ox, oy, w, h);
		ew = (w > OVL_MAX_W_DEF) ? OVL_MAX_W_DEF : w;
		eh = (h > OVL_MAX_H_DEF) ? OVL_MAX_H_DEF : h;
		for (int i = 0; i < n_items; i++) begin
			idle_pct = gap_pct;
			r = $urandom_range(99);
			if (r < 30) begin
				if (r < 4) begin
					x = $urandom_range(COORD_MAX);
					y = $urandom_range(COORD_MAX);
				end else if (r >= 10 && ew > 0 && eh > 0) begin
					x = $urandom_range(ew - 1);
					y = $urandom_range(eh - 1);
				end else begin
					x = $urandom_range(OVL_MAX_W_DEF - 1);
					y = $urandom_range(OVL_MAX_H_DEF - 1);
				end
				send(mk_item(OP_LOAD, x, y));
			end else begin
				if (r < 85) begin
					x = ox - 2 + int'($urandom_range(ew + 3));
					y = oy - 2 + int'($urandom_range(eh + 3));
				end else if (r < 90) begin
					x = $urandom_range(1) ? COORD_MAX : 0;
					y = $urandom_range(1) ? COORD_MAX : 0;
				end else begin
					x = $urandom_range(COORD_MAX);
					y = $urandom_range(COORD_MAX);
				end
				if (x < 0 || x > COORD_MAX)
					x = $urandom_range(COORD_MAX);
				if (y < 0 || y > COORD_MAX)
					y = $urandom_range(COORD_MAX);
				compose_at(x, y);
			end
		end
	endtask

	initial begin
		int seg_pct [3];
		seg_pct = '{33, 60, 0};
		arst_n = 1'b0;
		start = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = REG_OFFSET_X;
		cfg_wdata = '0;
		item = '0;
		idle_pct = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		configure(0, 0, 4, 2);
		idle_pct = 20;
		load_px(0, 0, 255, 0, 128, 0);
		load_px(1, 0, 255, 0, 128, 255);
		load_px(2, 0, 200, 100, 50, 128);
		load_px(3, 0, 255, 255, 255, 1);
		load_px(0, 1, 0, 0, 0, 254);
		load_px(1, 1, 255, 255, 255, 255);
		load_px(2, 1, 0, 255, 0, 255);
		load_px(3, 1, 17, 240, 99, 77);
		// outside the store: must not alias onto the first entries
		load_px(OVL_MAX_W_DEF, 0, 9, 9, 9, 255);
		load_px(0, OVL_MAX_H_DEF, 9, 9, 9, 255);
		load_px(COORD_MAX, COORD_MAX, 9, 9, 9, 255);
		load_px(511, 127, 9, 9, 9, 255);
		for (int y = 0; y < 2; y++)
			for (int x = 0; x < 4; x++)
				compose_px(x, y, ((x + y) % 2) ? 255 : 0);
		compose_px(4, 0, 255);
		compose_px(0, 2, 0);
		compose_px(COORD_MAX, COORD_MAX, 255);
		compose_px(0, COORD_MAX, 0);
		compose_px(COORD_MAX, 0, 255);

		for (int seg = 0; seg < 3; seg++)
			repeat (6) random_phase(70, seg_pct[seg]);

		drain();
		$display("Covered %0d composed pixels (%0d opaque, %0d blended, %0d unchanged)",
			sb.composed, sb.opaque, sb.blended, sb.unchanged);
		$display("and %0d overlay loads (%0d off the store) over %0d register settings",
			sb.loads, sb.dropped_loads, phases);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== rgba_overlay_alpha_compositor_unit.f =====
src/rgba_ovl_pkg.sv
src/rgba_ovl_ram.sv
src/rgba_overlay_alpha_compositor_unit.sv
dv/ovl_blend_sb_pkg.sv
dv/tb.sv
